/* rtl/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern search block.
// Used by mbps_cfg, mbps_match and masked_byte_pattern_search; no dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int ADDR_W            = 64;
  localparam int LEN_W             = 5;
  localparam int CARE_W            = 16;
  localparam int DIST_W            = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [63:0]       pattern_high;
    logic [63:0]       pattern_low;
    logic [CARE_W-1:0] care_mask;
    logic [LEN_W-1:0]  pattern_length;
  } cfg_t;

  // Compare results for the byte in flight
  typedef struct packed {
    logic              full_hit;   // candidate with the whole pattern inside the stream
    logic              any_hit;    // any candidate, partial ones included
    logic [DIST_W-1:0] full_dist;  // distance back to the full candidate's start
    logic [DIST_W-1:0] pick_dist;  // distance back to the earliest matching start
  } hit_t;

endpackage

/* rtl/mbps_cfg.sv */
// Configuration register file of the masked byte pattern search block.
// Depends on mbps_pkg for the register indexes and the cfg_t struct.
module mbps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output mbps_pkg::cfg_t                     cfg
);

  mbps_pkg::cfg_t cfg_r;

  // Take writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address   <= '0;
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.care_mask      <= '0;
      cfg_r.pattern_length <= mbps_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbps_pkg::REG_BASE_ADDRESS:   cfg_r.base_address   <= cfg_wdata;
        mbps_pkg::REG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_wdata;
        mbps_pkg::REG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_wdata;
        mbps_pkg::REG_CARE_MASK:
          cfg_r.care_mask <= cfg_wdata[mbps_pkg::CARE_W-1:0];
        mbps_pkg::REG_PATTERN_LENGTH:
          cfg_r.pattern_length <= cfg_wdata[mbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/mbps_match.sv */
// Parallel window compare: judges every candidate start in the byte window.
// Depends on mbps_pkg for cfg_t, hit_t and the field widths.
module mbps_match #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
  input  logic [MAX_PATTERN_BYTES*8-1:0]   window,      // byte d back at [8d+7:8d]
  input  mbps_pkg::cfg_t                   cfg,
  input  logic [mbps_pkg::ADDR_W-1:0]      bytes_seen,
  output mbps_pkg::hit_t                   hit
);

  localparam logic [mbps_pkg::LEN_W-1:0] MAX_LEN = mbps_pkg::LEN_W'(MAX_PATTERN_BYTES);

  logic [mbps_pkg::LEN_W-1:0]  eff_len;
  logic [MAX_PATTERN_BYTES-1:0] cand_ok;
  logic [127:0]                 pattern;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};

  // Clamp the length: zero acts as one, overlong saturates
  always_comb begin
    if (cfg.pattern_length == '0) begin
      eff_len = mbps_pkg::LEN_W'(1);
    end else if (cfg.pattern_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg.pattern_length;
    end
  end

  // Judge each start d bytes back on the positions that lie in the stream
  always_comb begin
    logic ok;
    for (int d = 0; d < MAX_PATTERN_BYTES; d++) begin
      ok = (bytes_seen >= mbps_pkg::ADDR_W'(d));
      for (int i = 0; i <= d; i++) begin
        if ((i == 0 || cfg.care_mask[i]) &&
            window[8*(d-i) +: 8] != pattern[8*i +: 8]) begin
          ok = 1'b0;
        end
      end
      cand_ok[d] = ok;
    end
  end

  // Select the full candidate and the earliest start overall
  always_comb begin
    hit.full_hit  = 1'b0;
    hit.any_hit   = 1'b0;
    hit.pick_dist = '0;
    hit.full_dist = mbps_pkg::DIST_W'(eff_len - mbps_pkg::LEN_W'(1));
    for (int d = 0; d < MAX_PATTERN_BYTES; d++) begin
      if (mbps_pkg::LEN_W'(d + 1) == eff_len && cand_ok[d]) begin
        hit.full_hit = 1'b1;
      end
      if (mbps_pkg::LEN_W'(d) < eff_len && cand_ok[d]) begin
        hit.any_hit   = 1'b1;
        hit.pick_dist = mbps_pkg::DIST_W'(d);
      end
    end
  end

endmodule

/* rtl/masked_byte_pattern_search.sv */
// Masked byte pattern search: scans a region's byte stream for the first pattern match.
// Top level; uses mbps_pkg, mbps_cfg and mbps_match.
//
// Takes one byte per clock, with no gaps unless a last byte stalls: a byte enters the
// input register, is compared against every candidate start in the window of the last
// MAX_PATTERN_BYTES bytes in one pass, and on the byte marked last a single result
// (found, base + first match offset) is loaded from the input register into the
// output register that drives out_valid. The output register lets the next region's bytes
// keep flowing while a result waits; only a new last byte stalls behind an untaken
// result. Write configuration only while no byte is in flight.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mbps_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mbps_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int RECENT_N = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;

  mbps_pkg::cfg_t      cfg;
  mbps_pkg::hit_t      hit;

  logic                s1_valid_r;
  mbps_pkg::in_item_t  s1_data_r;
  logic                s1_fire;

  logic [7:0]                     recent_r [RECENT_N];
  logic [MAX_PATTERN_BYTES*8-1:0] window;
  logic [mbps_pkg::ADDR_W-1:0]    bytes_seen_r;
  logic                           match_seen_r;
  logic [mbps_pkg::ADDR_W-1:0]    first_off_r;
  logic [mbps_pkg::ADDR_W-1:0]    first_off_nxt;

  logic                           out_valid_r;
  mbps_pkg::out_item_t            out_data_r;
  mbps_pkg::out_item_t            out_data_nxt;
  logic [mbps_pkg::ADDR_W-1:0]    off_a;
  logic [mbps_pkg::ADDR_W-1:0]    off_b;

  mbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A byte leaves the input register unless it is last and the result slot holds an untaken result
  assign s1_fire  = s1_valid_r && (!s1_data_r.last_byte || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Assemble the window: current byte, then earlier bytes most recent first
  always_comb begin
    window[7:0] = s1_data_r.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      window[8*k +: 8] = recent_r[k-1];
    end
  end

  mbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_match (
    .window     (window),
    .cfg        (cfg),
    .bytes_seen (bytes_seen_r),
    .hit        (hit)
  );

  // Advance the history of previous bytes
  always_ff @(posedge clk) begin
    if (s1_fire && !s1_data_r.last_byte) begin
      recent_r[0] <= s1_data_r.data_byte;
      for (int k = 1; k < RECENT_N; k++) begin
        recent_r[k] <= recent_r[k-1];
      end
    end
  end

  assign first_off_nxt = bytes_seen_r - mbps_pkg::ADDR_W'(hit.full_dist);

  // Stream state: byte count and the first full match; clear at region end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      match_seen_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_data_r.last_byte) begin
        bytes_seen_r <= '0;
        match_seen_r <= 1'b0;
      end else begin
        bytes_seen_r <= bytes_seen_r + mbps_pkg::ADDR_W'(1);
        if (hit.full_hit) begin
          match_seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_data_r.last_byte && !match_seen_r && hit.full_hit) begin
      first_off_r <= first_off_nxt;
    end
  end

  // Build the result: an earlier full match wins, else the earliest start now
  always_comb begin
    off_a = match_seen_r ? first_off_r : bytes_seen_r;
    off_b = match_seen_r ? '0 : mbps_pkg::ADDR_W'(hit.pick_dist);
    out_data_nxt.found         = match_seen_r || hit.any_hit;
    out_data_nxt.match_address = out_data_nxt.found ?
                                 (cfg.base_address + off_a - off_b) : '0;
  end

  // Output register: load on a last byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_data_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_data_r.last_byte) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A miss carries a zero address
  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.match_address == '0)
    else $error("miss result with nonzero address");

  // Region end clears the stream state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_data_r.last_byte |=> bytes_seen_r == '0 && !match_seen_r)
    else $error("stream state not cleared after last byte");

  // Each inner byte advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_data_r.last_byte |=>
      bytes_seen_r == $past(bytes_seen_r) + mbps_pkg::ADDR_W'(1))
    else $error("byte count did not advance");

  // A recorded match is only dropped at region end or reset
  a_match_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(match_seen_r) |-> !$past(rst_n) || $past(s1_fire && s1_data_r.last_byte))
    else $error("match flag lost inside a region");

  // A last byte never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_data_r.last_byte |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");

endmodule
